>>> sv/aebf_pkg.sv
// Package for the audio elastic buffer core: operation codes, rate adjust codes,
// the stage-one control struct and the default sizing constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package aebf_pkg;

  typedef enum logic [1:0] {
    OP_WRITE    = 2'd0,
    OP_READ     = 2'd1,
    OP_FEEDBACK = 2'd2,
    OP_RESET    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    RA_NONE = 2'd0,
    RA_UP   = 2'd1,
    RA_DOWN = 2'd2,
    RA_RSVD = 2'd3
  } rate_adj_t;

  localparam int DEF_PACKETS_IN_RING = 20;
  localparam int DEF_PACKET_SAMPLES  = 100;

  localparam int SAMPLE_W = 16;
  localparam int LEN_W    = 7;
  localparam int FB_W     = 24;
  localparam int FILL_W   = 11;
  localparam int GAIN_W   = 9;

  localparam logic [FB_W-1:0] FB_STEP = 24'd100;

  localparam logic [1:0] CFG_NOMINAL = 2'd0;
  localparam logic [1:0] CFG_MODE    = 2'd1;
  localparam logic [1:0] CFG_GAIN    = 2'd2;

  localparam logic [FB_W-1:0]   NOMINAL_RESET = 24'd786432;
  localparam logic [GAIN_W-1:0] GAIN_RESET    = 9'd256;

  typedef struct packed {
    logic              sample_valid;
    logic              dropped;
    logic              underrun;
    logic              start;
    logic [FB_W-1:0]   feedback;
    logic [FILL_W-1:0] fill;
  } aebf_s1_t;

endpackage
`default_nettype wire

>>> sv/aebf_ring.sv
// Sample ring storage: one write port and one read port with registered read data.
// Depends on aebf_pkg for the sample width.
`timescale 1ns / 1ps
`default_nettype none
module aebf_ring
  import aebf_pkg::*;
#(
  parameter int DEPTH = DEF_PACKETS_IN_RING * DEF_PACKET_SAMPLES,
  localparam int POS_W = $clog2(DEPTH)
) (
  input  wire logic                clk,
  input  wire logic                wr_en,
  input  wire logic [POS_W-1:0]    wr_addr,
  input  wire logic [SAMPLE_W-1:0] wr_data,
  input  wire logic                rd_en,
  input  wire logic [POS_W-1:0]    rd_addr,
  output logic      [SAMPLE_W-1:0] rd_data
);

  logic [SAMPLE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

>>> sv/aebf_ctrl.sv
// Ring control: positions, packet admission, playback start, read serving and
// rate feedback, registered into the stage-one control struct.
// Depends on aebf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module aebf_ctrl
  import aebf_pkg::*;
#(
  parameter int PACKETS_IN_RING = DEF_PACKETS_IN_RING,
  parameter int PACKET_SAMPLES  = DEF_PACKET_SAMPLES,
  localparam int DEPTH = PACKETS_IN_RING * PACKET_SAMPLES,
  localparam int POS_W = $clog2(DEPTH)
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                accept,
  input  wire logic [1:0]          op,
  input  wire logic [SAMPLE_W-1:0] sample,
  input  wire logic                first,
  input  wire logic [LEN_W-1:0]    len,
  input  wire logic [FB_W-1:0]     nominal,
  output logic                     wr_en,
  output logic      [POS_W-1:0]    wr_addr,
  output logic      [SAMPLE_W-1:0] wr_data,
  output logic                     rd_en,
  output logic      [POS_W-1:0]    rd_addr,
  output logic                     s1_valid_r,
  output aebf_s1_t                 s1_r
);

  localparam logic [POS_W:0]   DEPTH_C = (POS_W+1)'(DEPTH);
  localparam logic [POS_W-1:0] LAST_C  = POS_W'(DEPTH - 1);
  localparam logic [POS_W-1:0] HALF_C  = POS_W'(DEPTH / 2);
  localparam logic [POS_W-1:0] HI_C    = POS_W'(DEPTH * 3 / 4);
  localparam logic [POS_W-1:0] LO_C    = POS_W'(DEPTH / 4);
  localparam logic [POS_W:0]   PS_C    = (POS_W+1)'(PACKET_SAMPLES);

  logic [POS_W-1:0] wp_r, wp_nxt;
  logic [POS_W-1:0] rp_r, rp_nxt;
  logic             play_r, play_nxt;
  logic [POS_W-1:0] flr_r, flr_nxt;
  rate_adj_t        ra_r, ra_nxt;
  logic [LEN_W-1:0] wl_r, wl_nxt;
  logic             wa_r, wa_nxt;
  logic             srv_r, srv_nxt;
  aebf_s1_t         s1_nxt;

  logic [POS_W-1:0] fill;
  logic [POS_W:0]   free;
  logic [POS_W:0]   fill_after;
  logic [LEN_W-1:0] wl_v;
  logic             acc_v;
  logic             srv_v;
  rate_adj_t        ra_v;
  logic [FB_W:0]    fb_sum;

  always_comb begin
    if (wp_r >= rp_r) begin
      fill = wp_r - rp_r;
    end else begin
      fill = POS_W'((POS_W+1)'(wp_r) + DEPTH_C - (POS_W+1)'(rp_r));
    end
    free   = DEPTH_C - (POS_W+1)'(fill);
    fb_sum = (FB_W+1)'(nominal) + (FB_W+1)'(FB_STEP);
  end

  assign wr_addr = wp_r;
  assign wr_data = sample;
  assign rd_addr = rp_r;

  always_comb begin
    wp_nxt     = wp_r;
    rp_nxt     = rp_r;
    play_nxt   = play_r;
    flr_nxt    = flr_r;
    ra_nxt     = ra_r;
    wl_nxt     = wl_r;
    wa_nxt     = wa_r;
    srv_nxt    = srv_r;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    s1_nxt     = '0;
    fill_after = (POS_W+1)'(fill);
    wl_v       = first ? len : wl_r;
    acc_v      = first ? (free > (POS_W+1)'(len)) : wa_r;
    srv_v      = first ? ((POS_W+1)'(fill) > PS_C) : srv_r;
    ra_v       = ra_r;
    if (flr_r > HI_C) begin
      ra_v = RA_DOWN;
    end else if (flr_r < LO_C) begin
      ra_v = RA_UP;
    end
    if (accept) begin
      unique case (op_t'(op))
        OP_WRITE: begin
          if (first || wl_r != '0) begin
            if (wl_v != '0) begin
              if (acc_v) begin
                wr_en      = 1'b1;
                wp_nxt     = (wp_r == LAST_C) ? '0 : wp_r + 1'b1;
                fill_after = (POS_W+1)'(fill) + 1'b1;
              end
              wl_v = wl_v - 1'b1;
            end
            s1_nxt.dropped = !acc_v;
            if (wl_v == '0 && !play_r && wp_nxt >= HALF_C) begin
              play_nxt     = 1'b1;
              s1_nxt.start = 1'b1;
            end
          end
          wl_nxt = wl_v;
          wa_nxt = acc_v;
        end
        OP_READ: begin
          if (first) begin
            flr_nxt = fill;
          end
          srv_nxt = srv_v;
          if (srv_v && fill != '0) begin
            rd_en               = 1'b1;
            rp_nxt              = (rp_r == LAST_C) ? '0 : rp_r + 1'b1;
            fill_after          = (POS_W+1)'(fill) - 1'b1;
            s1_nxt.sample_valid = 1'b1;
          end else begin
            s1_nxt.underrun = 1'b1;
          end
        end
        OP_FEEDBACK: begin
          ra_nxt = ra_v;
          case (ra_v)
            RA_UP:   s1_nxt.feedback = fb_sum[FB_W] ? '1 : fb_sum[FB_W-1:0];
            RA_DOWN: s1_nxt.feedback = (nominal < FB_STEP) ? '0 : nominal - FB_STEP;
            default: s1_nxt.feedback = nominal;
          endcase
        end
        OP_RESET: begin
          wp_nxt     = '0;
          rp_nxt     = '0;
          play_nxt   = 1'b0;
          wl_nxt     = '0;
          wa_nxt     = 1'b0;
          srv_nxt    = 1'b0;
          fill_after = '0;
        end
        default: begin
        end
      endcase
    end
    s1_nxt.fill = FILL_W'(fill_after);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r       <= '0;
      rp_r       <= '0;
      play_r     <= 1'b0;
      flr_r      <= '0;
      ra_r       <= RA_NONE;
      wl_r       <= '0;
      wa_r       <= 1'b0;
      srv_r      <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      wp_r       <= wp_nxt;
      rp_r       <= rp_nxt;
      play_r     <= play_nxt;
      flr_r      <= flr_nxt;
      ra_r       <= ra_nxt;
      wl_r       <= wl_nxt;
      wa_r       <= wa_nxt;
      srv_r      <= srv_nxt;
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
  end

endmodule
`default_nettype wire

>>> sv/aebf_gain.sv
// Output stage: applies the speaker gain with saturation to ring samples in speaker
// mode and registers the result item. Depends on aebf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module aebf_gain
  import aebf_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                s1_valid,
  input  wire aebf_s1_t            s1,
  input  wire logic [SAMPLE_W-1:0] rd_data,
  input  wire logic                speaker_mode,
  input  wire logic [GAIN_W-1:0]   speaker_gain,
  output logic                     out_valid_r,
  output logic      [SAMPLE_W-1:0] sample_r,
  output logic                     dropped_r,
  output logic                     underrun_r,
  output logic                     start_r,
  output logic      [FB_W-1:0]     feedback_r,
  output logic      [FILL_W-1:0]   fill_r
);

  localparam int PROD_W = SAMPLE_W + GAIN_W + 1;

  logic signed [PROD_W-1:0]   prod;
  logic signed [PROD_W-9:0]   scaled;
  logic        [SAMPLE_W-1:0] sat;
  logic        [SAMPLE_W-1:0] sample_nxt;

  always_comb begin
    prod   = $signed(rd_data) * $signed({1'b0, speaker_gain});
    scaled = prod[PROD_W-1:8];
    if (scaled > (PROD_W-8)'(32767)) begin
      sat = 16'h7FFF;
    end else if (scaled < -(PROD_W-8)'(32768)) begin
      sat = 16'h8000;
    end else begin
      sat = scaled[SAMPLE_W-1:0];
    end
    if (!s1.sample_valid) begin
      sample_nxt = '0;
    end else if (speaker_mode) begin
      sample_nxt = sat;
    end else begin
      sample_nxt = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    sample_r   <= sample_nxt;
    dropped_r  <= s1.dropped;
    underrun_r <= s1.underrun;
    start_r    <= s1.start;
    feedback_r <= s1.feedback;
    fill_r     <= s1.fill;
  end

endmodule
`default_nettype wire

>>> sv/audio_elastic_buffer_feedback_core.sv
// Top level of the audio elastic buffer with rate feedback. Depends on aebf_pkg,
// aebf_ctrl, aebf_ring and aebf_gain.
// Each result passes from the accepted request through the stage-one registers, then the output registers.
// Throughput: one request per cycle; busy stays low, the ring read port is registered.
// Reset: synchronous active low; clears positions, flags and registers, not the ring.
// The receiver cannot stall: each result is shown for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none
module audio_elastic_buffer_feedback_core
  import aebf_pkg::*;
#(
  parameter int PACKETS_IN_RING = DEF_PACKETS_IN_RING,
  parameter int PACKET_SAMPLES  = DEF_PACKET_SAMPLES
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [1:0]                 in_op,
  input  wire logic signed [SAMPLE_W-1:0] in_sample_in,
  input  wire logic                       in_first_of_packet,
  input  wire logic [LEN_W-1:0]           in_packet_len,
  output logic                            out_valid,
  output logic signed [SAMPLE_W-1:0]      out_sample_out,
  output logic                            out_packet_dropped,
  output logic                            out_underrun,
  output logic                            out_start_playback,
  output logic      [FB_W-1:0]            out_rate_word,
  output logic      [FILL_W-1:0]          out_fill_level,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [1:0]                 cfg_index,
  input  wire logic [FB_W-1:0]            cfg_data
);

  localparam int DEPTH = PACKETS_IN_RING * PACKET_SAMPLES;
  localparam int POS_W = $clog2(DEPTH);

  logic [FB_W-1:0]   nominal_r;
  logic              mode_r;
  logic [GAIN_W-1:0] gain_r;

  logic                accept;
  logic                wr_en;
  logic [POS_W-1:0]    wr_addr;
  logic [SAMPLE_W-1:0] wr_data;
  logic                rd_en;
  logic [POS_W-1:0]    rd_addr;
  logic [SAMPLE_W-1:0] rd_data;
  logic                s1_valid;
  aebf_s1_t            s1;
  logic [SAMPLE_W-1:0] sample_q;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nominal_r <= NOMINAL_RESET;
      mode_r    <= 1'b0;
      gain_r    <= GAIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_NOMINAL: nominal_r <= cfg_data;
        CFG_MODE:    mode_r    <= cfg_data[0];
        CFG_GAIN:    gain_r    <= cfg_data[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  aebf_ctrl #(
    .PACKETS_IN_RING(PACKETS_IN_RING),
    .PACKET_SAMPLES (PACKET_SAMPLES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .op        (in_op),
    .sample    (in_sample_in),
    .first     (in_first_of_packet),
    .len       (in_packet_len),
    .nominal   (nominal_r),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .s1_valid_r(s1_valid),
    .s1_r      (s1)
  );

  aebf_ring #(
    .DEPTH(DEPTH)
  ) u_ring (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  aebf_gain u_gain (
    .clk         (clk),
    .rst_n       (rst_n),
    .s1_valid    (s1_valid),
    .s1          (s1),
    .rd_data     (rd_data),
    .speaker_mode(mode_r),
    .speaker_gain(gain_r),
    .out_valid_r (out_valid),
    .sample_r    (sample_q),
    .dropped_r   (out_packet_dropped),
    .underrun_r  (out_underrun),
    .start_r     (out_start_playback),
    .feedback_r  (out_rate_word),
    .fill_r      (out_fill_level)
  );

  assign out_sample_out = $signed(sample_q);

endmodule
`default_nettype wire

>>> verif/audio_elastic_buffer_feedback_checker.sv
// Checker for the audio elastic buffer core: keeps its own copy of the ring, positions,
// registers and feedback state, predicts every result and compares it field by field.
// Depends on aebf_pkg only.
`timescale 1ns / 1ps
module audio_elastic_buffer_feedback_checker
  import aebf_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic                busy,
  input  wire logic [1:0]          in_op,
  input  wire logic [SAMPLE_W-1:0] in_sample_in,
  input  wire logic                in_first_of_packet,
  input  wire logic [LEN_W-1:0]    in_packet_len,
  input  wire logic                out_valid,
  input  wire logic [SAMPLE_W-1:0] out_sample_out,
  input  wire logic                out_packet_dropped,
  input  wire logic                out_underrun,
  input  wire logic                out_start_playback,
  input  wire logic [FB_W-1:0]     out_rate_word,
  input  wire logic [FILL_W-1:0]   out_fill_level,
  input  wire logic                cfg_valid,
  input  wire logic                cfg_ready,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [FB_W-1:0]     cfg_data,
  output int                       error_count,
  output int                       pending_count
);

  localparam int RING_SIZE = DEF_PACKETS_IN_RING * DEF_PACKET_SAMPLES;
  localparam int FB_MAX    = (1 << FB_W) - 1;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                dropped;
    logic                underrun;
    logic                playback;
    logic [FB_W-1:0]     feedback;
    logic [FILL_W-1:0]   fill;
  } buffer_result_t;

  logic [SAMPLE_W-1:0] sample_store [RING_SIZE];
  int                  wr_pos;
  int                  rd_pos;
  int                  wr_left;
  int                  last_read_fill;
  logic                playing;
  logic                write_ok;
  logic                read_ok;
  rate_adj_t           adjust;
  logic [FB_W-1:0]     nominal;
  logic                speaker_on;
  logic [GAIN_W-1:0]   gain_q8;

  buffer_result_t expected_outputs [$];

  function automatic int ring_occupancy();
    if (wr_pos >= rd_pos) return wr_pos - rd_pos;
    return RING_SIZE - rd_pos + wr_pos;
  endfunction

  function automatic logic [SAMPLE_W-1:0] scale_by_gain(input logic [SAMPLE_W-1:0] raw);
    int s;
    int q;
    s = int'($signed(raw));
    q = (s * int'(gain_q8)) >>> 8;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[SAMPLE_W-1:0];
  endfunction

  function automatic buffer_result_t predict_buffer_item(input logic [1:0] op,
                                                         input logic [SAMPLE_W-1:0] smp,
                                                         input logic first,
                                                         input logic [LEN_W-1:0] len);
    buffer_result_t r;
    logic           in_pkt;
    int             f;
    r = '0;
    case (op_t'(op))
      OP_WRITE: begin
        in_pkt = first || (wr_left > 0);
        if (first) begin
          write_ok = (RING_SIZE - ring_occupancy()) > int'(len);
          wr_left  = int'(len);
        end
        if (in_pkt) begin
          if (wr_left > 0) begin
            if (write_ok) begin
              sample_store[wr_pos] = smp;
              wr_pos = (wr_pos == RING_SIZE - 1) ? 0 : wr_pos + 1;
            end
            wr_left--;
          end
          if (!write_ok) r.dropped = 1'b1;
          if (wr_left == 0 && !playing && wr_pos >= RING_SIZE / 2) begin
            playing    = 1'b1;
            r.playback = 1'b1;
          end
        end
      end
      OP_READ: begin
        if (first) begin
          last_read_fill = ring_occupancy();
          read_ok        = last_read_fill > DEF_PACKET_SAMPLES;
        end
        if (read_ok && ring_occupancy() > 0) begin
          r.sample = speaker_on ? scale_by_gain(sample_store[rd_pos]) : sample_store[rd_pos];
          rd_pos   = (rd_pos == RING_SIZE - 1) ? 0 : rd_pos + 1;
        end else begin
          r.underrun = 1'b1;
        end
      end
      OP_FEEDBACK: begin
        if (last_read_fill > RING_SIZE * 3 / 4) adjust = RA_DOWN;
        else if (last_read_fill < RING_SIZE / 4) adjust = RA_UP;
        f = int'(nominal);
        if (adjust == RA_UP) f = f + int'(FB_STEP);
        else if (adjust == RA_DOWN) f = f - int'(FB_STEP);
        if (f < 0) f = 0;
        if (f > FB_MAX) f = FB_MAX;
        r.feedback = f[FB_W-1:0];
      end
      default: begin
        wr_pos  = 0;
        rd_pos  = 0;
        playing = 1'b0;
        wr_left = 0;
        write_ok = 1'b0;
        read_ok  = 1'b0;
      end
    endcase
    r.fill = FILL_W'(ring_occupancy());
    return r;
  endfunction

  function automatic void compare_field(input string field, input longint want_v,
                                        input longint got_v);
    if (want_v != got_v) begin
      $error("%s: expected %0d, got %0d", field, want_v, got_v);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    buffer_result_t want;
    if (!rst_n) begin
      wr_pos         = 0;
      rd_pos         = 0;
      wr_left        = 0;
      last_read_fill = 0;
      playing        = 1'b0;
      write_ok       = 1'b0;
      read_ok        = 1'b0;
      adjust         = RA_NONE;
      nominal        = NOMINAL_RESET;
      speaker_on     = 1'b0;
      gain_q8        = GAIN_RESET;
      expected_outputs.delete();
      error_count    = 0;
      pending_count  = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_NOMINAL: nominal = cfg_data;
          CFG_MODE:    speaker_on = cfg_data[0];
          CFG_GAIN:    gain_q8 = cfg_data[GAIN_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        expected_outputs.push_back(predict_buffer_item(in_op, in_sample_in,
                                                       in_first_of_packet, in_packet_len));
      end
      if (out_valid) begin
        if (expected_outputs.size() == 0) begin
          $error("result with no request outstanding: sample_out %0d, fill_level %0d",
                 $signed(out_sample_out), out_fill_level);
          error_count++;
        end else begin
          want = expected_outputs.pop_front();
          compare_field("sample_out", longint'($signed(want.sample)),
                        longint'($signed(out_sample_out)));
          compare_field("packet_dropped", longint'(want.dropped), longint'(out_packet_dropped));
          compare_field("underrun", longint'(want.underrun), longint'(out_underrun));
          compare_field("start_playback", longint'(want.playback),
                        longint'(out_start_playback));
          compare_field("rate_word", longint'(want.feedback), longint'(out_rate_word));
          compare_field("fill_level", longint'(want.fill), longint'(out_fill_level));
        end
      end
      pending_count = expected_outputs.size();
    end
  end

endmodule

>>> verif/audio_elastic_buffer_feedback_core_tb.sv
// Testbench top for the audio elastic buffer core: clock, reset, register writes and
// request traffic with random gaps; the verdict comes from the checker's error and pending counts.
// Depends on aebf_pkg, the core and audio_elastic_buffer_feedback_checker.
`timescale 1ns / 1ps
module audio_elastic_buffer_feedback_core_tb;
  import aebf_pkg::*;

  localparam logic [1:0] CFG_SPARE = 2'd3;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [1:0]          in_op = OP_WRITE;
  logic [SAMPLE_W-1:0] in_sample_in = '0;
  logic                in_first_of_packet = 1'b0;
  logic [LEN_W-1:0]    in_packet_len = '0;
  logic                out_valid;
  logic [SAMPLE_W-1:0] out_sample_out;
  logic                out_packet_dropped;
  logic                out_underrun;
  logic                out_start_playback;
  logic [FB_W-1:0]     out_rate_word;
  logic [FILL_W-1:0]   out_fill_level;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [1:0]          cfg_index = CFG_NOMINAL;
  logic [FB_W-1:0]     cfg_data = '0;
  int                  mismatch_total;
  int                  results_waiting;
  int                  items_sent = 0;
  bit                  gaps_on = 1'b1;

  audio_elastic_buffer_feedback_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_sample_in(in_sample_in), .in_first_of_packet(in_first_of_packet),
    .in_packet_len(in_packet_len), .out_valid(out_valid), .out_sample_out(out_sample_out),
    .out_packet_dropped(out_packet_dropped), .out_underrun(out_underrun),
    .out_start_playback(out_start_playback), .out_rate_word(out_rate_word),
    .out_fill_level(out_fill_level), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  audio_elastic_buffer_feedback_checker checker_i (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_sample_in(in_sample_in), .in_first_of_packet(in_first_of_packet),
    .in_packet_len(in_packet_len), .out_valid(out_valid), .out_sample_out(out_sample_out),
    .out_packet_dropped(out_packet_dropped), .out_underrun(out_underrun),
    .out_start_playback(out_start_playback), .out_rate_word(out_rate_word),
    .out_fill_level(out_fill_level), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .error_count(mismatch_total), .pending_count(results_waiting)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 15))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic issue(input op_t op, input logic [SAMPLE_W-1:0] smp, input logic first,
                       input logic [LEN_W-1:0] len);
    int n;
    int r;
    start              <= 1'b1;
    in_op              <= op;
    in_sample_in       <= smp;
    in_first_of_packet <= first;
    in_packet_len      <= len;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    n = 0;
    if (gaps_on) begin
      r = $urandom_range(0, 99);
      if (r >= 95) n = $urandom_range(8, 40);
      else if (r >= 60) n = $urandom_range(1, 3);
    end
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic quiesce();
    start <= 1'b0;
    @(posedge clk);
    while (results_waiting != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [FB_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_setting(input logic [FB_W-1:0] nom, input logic mode,
                               input logic [GAIN_W-1:0] gain);
    quiesce();
    write_reg(CFG_NOMINAL, nom);
    write_reg(CFG_MODE, FB_W'(mode));
    write_reg(CFG_GAIN, FB_W'(gain));
  endtask

  task automatic write_packet(input int min_len);
    int len;
    int stop_at;
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) len = 0;
    else if (r < 10) len = $urandom_range(101, 127);
    else if (r < 20) len = $urandom_range(1, min_len);
    else len = $urandom_range(min_len, 100);
    stop_at = (len == 0) ? 1 : len;
    if (len > 1 && $urandom_range(0, 9) == 0) stop_at = $urandom_range(1, len - 1);
    for (int k = 0; k < stop_at; k++) begin
      issue(OP_WRITE, pick_sample(), k == 0, (k == 0) ? LEN_W'(len) : LEN_W'($urandom));
    end
    if ($urandom_range(0, 19) == 0) begin
      repeat ($urandom_range(1, 3)) issue(OP_WRITE, pick_sample(), 1'b0, LEN_W'($urandom));
    end
  endtask

  task automatic read_packet(input int max_len);
    int len;
    if (max_len >= DEF_PACKET_SAMPLES && $urandom_range(0, 1) == 1) len = DEF_PACKET_SAMPLES;
    else len = $urandom_range(1, max_len);
    for (int k = 0; k < len; k++) begin
      issue(OP_READ, SAMPLE_W'($urandom), k == 0, LEN_W'($urandom));
    end
  endtask

  task automatic run_traffic(input int budget, input int w_write, input int w_read,
                             input int w_tick, input int w_reset, input int min_len,
                             input int max_read);
    int base;
    int pick;
    int top_op;
    base   = items_sent;
    top_op = (w_reset > 0) ? 3 : 2;
    while (items_sent - base < budget) begin
      gaps_on = ($urandom_range(0, 4) != 0);
      pick    = $urandom_range(0, w_write + w_read + w_tick + w_reset + 2);
      if (pick < w_write) begin
        write_packet(min_len);
      end else if (pick < w_write + w_read) begin
        read_packet(max_read);
      end else if (pick < w_write + w_read + w_tick) begin
        issue(OP_FEEDBACK, SAMPLE_W'($urandom), 1'($urandom), LEN_W'($urandom));
      end else if (pick < w_write + w_read + w_tick + w_reset) begin
        issue(OP_RESET, SAMPLE_W'($urandom), 1'($urandom), LEN_W'($urandom));
      end else begin
        issue(op_t'($urandom_range(0, top_op)), SAMPLE_W'($urandom), 1'($urandom),
              LEN_W'($urandom));
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Short directed pass with the reset register values.
    issue(OP_WRITE, 16'h0000, 1'b1, 7'd0);
    issue(OP_WRITE, 16'h1234, 1'b0, 7'd5);
    issue(OP_READ, 16'h0000, 1'b1, 7'd0);
    issue(OP_READ, 16'hFFFF, 1'b0, 7'd127);
    issue(OP_FEEDBACK, 16'h0000, 1'b0, 7'd0);
    issue(OP_WRITE, 16'h7FFF, 1'b1, 7'd4);
    issue(OP_WRITE, 16'h8000, 1'b0, 7'd0);
    issue(OP_WRITE, 16'h0001, 1'b0, 7'd127);
    issue(OP_WRITE, 16'hFFFF, 1'b0, 7'd0);
    issue(OP_READ, 16'h0000, 1'b1, 7'd0);
    issue(OP_READ, 16'h0000, 1'b0, 7'd0);
    issue(OP_RESET, 16'hFFFF, 1'b1, 7'd127);
    issue(OP_WRITE, 16'h8000, 1'b1, 7'd127);
    issue(OP_WRITE, 16'h7FFF, 1'b0, 7'd0);
    issue(OP_RESET, 16'h0000, 1'b0, 7'd0);
    issue(OP_FEEDBACK, 16'hFFFF, 1'b1, 7'd127);
    issue(OP_WRITE, 16'hAAAA, 1'b0, 7'd42);

    apply_setting(24'hFFFFFF, 1'b1, 9'h1FF);
    write_reg(CFG_SPARE, FB_W'($urandom));
    run_traffic(700, 90, 3, 5, 0, 60, 20);

    apply_setting(24'd0, 1'b1, 9'd0);
    run_traffic(350, 90, 3, 5, 0, 80, 20);

    apply_setting(FB_W'($urandom), 1'b0, GAIN_W'($urandom));
    run_traffic(150, 20, 70, 8, 0, 60, 100);

    apply_setting(NOMINAL_RESET, 1'b1, GAIN_W'($urandom_range(0, 511)));
    run_traffic(60, 45, 40, 8, 4, 1, 100);
    quiesce();
    run_traffic(60, 45, 40, 8, 4, 1, 100);

    quiesce();
    if (mismatch_total == 0 && results_waiting == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/aebf_pkg.sv
sv/aebf_ring.sv
sv/aebf_ctrl.sv
sv/aebf_gain.sv
sv/audio_elastic_buffer_feedback_core.sv
verif/audio_elastic_buffer_feedback_checker.sv
verif/audio_elastic_buffer_feedback_core_tb.sv
